[hw/rtl/hwsd_pkg.sv]
// hwsd_pkg: shared types and constants for the hall wheel speed/direction block
// sequencer states, register indexes, reset values and datapath widths
// no dependencies
package hwsd_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_TRAVEL   = 3'd0,
    REG_TOP      = 3'd1,
    REG_FULL     = 3'd2,
    REG_STOP     = 3'd3,
    REG_INVERT   = 3'd4,
    REG_REVERSE  = 3'd5
  } hwsd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV_MAG,
    ST_READ,
    ST_WRITE,
    ST_DIV_AVG,
    ST_DONE
  } hwsd_state_t;

  localparam int AVG_LEN_DEF = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MAG_W       = 7;
  localparam int MS_W        = 16;
  localparam int NUM_W       = 20;          // travel * 10
  localparam int DEN_W       = 32;          // top_speed * ticks
  localparam int PROD_W      = 27;          // travel * 10 * full_scale
  localparam int QSHIFT      = MAG_W - 1;   // first divider shift
  localparam int DS_W        = DEN_W + QSHIFT;

  localparam logic [15:0]      TRAVEL_RST = 16'd100;
  localparam logic [15:0]      TOP_RST    = 16'd100;
  localparam logic [MAG_W-1:0] FULL_RST   = 7'd127;
  localparam logic [15:0]      STOP_RST   = 16'd500;
  localparam logic [MS_W-1:0]  MS_MAX     = 16'hFFFF;

endpackage

[hw/rtl/hall_wheel_speed_direction.sv]
// hall_wheel_speed_direction: trigger-driven wheel speed, rolling average, signed axis
// a stop report runs READ, WRITE, DONE; a trigger report runs MUL, SCALE, the 7-step
// magnitude divider in DIV_MAG when it runs, READ, WRITE, DIV_AVG, DONE; a tick with no
// result stays idle; one request at a time, the next taken back in idle after the result
// is put in the output register, which only waits while the previous result is unaccepted
// reset: sync active-low; control state, ring valid bits, register defaults; uses hwsd_pkg
module hall_wheel_speed_direction #(
  parameter int AVG_LEN = hwsd_pkg::AVG_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_hall_inner,
  input  logic                            in_hall_middle,
  input  logic                            in_hall_outer,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               out_axis_value,
  output logic                            out_stop_report,
  input  logic                            cfg_wr_en,
  input  logic [hwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAG_W   = hwsd_pkg::MAG_W;
  localparam int PTR_W   = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int TOT_MAX = AVG_LEN * ((1 << MAG_W) - 1);
  localparam int TOT_W   = $clog2(TOT_MAX + 1);
  localparam int PROD_W  = hwsd_pkg::PROD_W;
  localparam int DS_W    = hwsd_pkg::DS_W;
  localparam int DEN_W   = hwsd_pkg::DEN_W;
  localparam int NUM_W   = hwsd_pkg::NUM_W;
  localparam int MS_W    = hwsd_pkg::MS_W;
  // average by reciprocal multiply, exact over the whole total range
  localparam int RCP_SH  = TOT_W + 7;
  localparam int RCP_M   = ((1 << RCP_SH) + AVG_LEN - 1) / AVG_LEN;
  localparam int AVG_PW  = RCP_SH + MAG_W + 1;

  // configuration registers
  logic [15:0]      travel_r, top_r, stop_delay_r;
  logic [MAG_W-1:0] full_r;
  logic             invert_r, reverse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      travel_r     <= hwsd_pkg::TRAVEL_RST;
      top_r        <= hwsd_pkg::TOP_RST;
      full_r       <= hwsd_pkg::FULL_RST;
      stop_delay_r <= hwsd_pkg::STOP_RST;
      invert_r     <= 1'b0;
      reverse_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hwsd_pkg::REG_TRAVEL:  travel_r     <= cfg_wdata;
        hwsd_pkg::REG_TOP:     top_r        <= cfg_wdata;
        hwsd_pkg::REG_FULL:    full_r       <= cfg_wdata[MAG_W-1:0];
        hwsd_pkg::REG_STOP:    stop_delay_r <= cfg_wdata;
        hwsd_pkg::REG_INVERT:  invert_r     <= cfg_wdata[0];
        hwsd_pkg::REG_REVERSE: reverse_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ring memory, registered read
  logic [MAG_W-1:0] ring_mem [AVG_LEN];
  logic [MAG_W-1:0] ring_rd_r;
  logic [AVG_LEN-1:0] ring_vld_r;

  // control and datapath registers
  hwsd_pkg::hwsd_state_t state_r, state_nxt;
  logic [2:0]        prev_r;
  logic [MS_W-1:0]   elapsed_r;
  logic              halted_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [TOT_W-1:0]  total_r;
  logic [MS_W-1:0]   t_r;
  logic              stop_r;
  logic              neg_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] rem_r;
  logic [DS_W-1:0]   ds_r;
  logic [MAG_W-1:0]  q_r;
  logic [MAG_W-1:0]  mag_r;
  logic [2:0]        cnt_r;
  logic              out_valid_r;
  logic signed [7:0] out_axis_r;
  logic              out_stop_r;

  // request decode
  logic [2:0]      now;
  logic [MS_W-1:0] el_inc;
  logic            trig, stop_hit, accept;
  logic [2:0]      prev_succ;
  logic            dir_neg;

  assign now      = 3'(in_hall_inner) + {1'b0, in_hall_middle, 1'b0}
                  + {1'b0, in_hall_outer, in_hall_outer};
  assign el_inc   = (elapsed_r == hwsd_pkg::MS_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign trig     = (now != 3'd0) && (now != prev_r);
  assign stop_hit = !trig && !halted_r && (el_inc > stop_delay_r);
  assign accept   = in_valid && in_ready;
  assign prev_succ = (prev_r == 3'd3) ? 3'd1 : prev_r + 3'd1;
  // backward when the previous weight is 1, 2 or 3 and this is not its successor, xor reverse
  assign dir_neg  = ((prev_r == 3'd1 || prev_r == 3'd2 || prev_r == 3'd3) && now != prev_succ)
                    ^ reverse_r;

  // divider step, one quotient bit a cycle
  logic              div_ge;
  logic [PROD_W-1:0] div_rem;
  logic [MAG_W-1:0]  div_q;
  assign div_ge  = {{(DS_W-PROD_W){1'b0}}, rem_r} >= ds_r;
  assign div_rem = div_ge ? rem_r - ds_r[PROD_W-1:0] : rem_r;
  assign div_q   = {q_r[MAG_W-2:0], div_ge};

  // ring update
  logic [PTR_W-1:0] ptr_inc;
  logic [MAG_W-1:0] old_mag;
  logic [TOT_W-1:0] total_nxt;
  assign ptr_inc   = (ptr_r == PTR_W'(AVG_LEN - 1)) ? '0 : ptr_r + 1'b1;
  assign old_mag   = ring_vld_r[ptr_r] ? ring_rd_r : '0;
  assign total_nxt = total_r - TOT_W'(old_mag) + TOT_W'(mag_r);

  logic [AVG_PW-1:0] avg_prod;
  assign avg_prod = AVG_PW'(total_r) * AVG_PW'(RCP_M);

  // axis value
  logic signed [8:0] mag_s, val_s;
  assign mag_s = invert_r ? $signed({2'b00, full_r}) - $signed({2'b00, q_r})
                          : $signed({2'b00, q_r});
  assign val_s = neg_r ? -mag_s : mag_s;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hwsd_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      hwsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (trig)          state_nxt = hwsd_pkg::ST_MUL;
          else if (stop_hit) state_nxt = hwsd_pkg::ST_READ;
        end
      end
      hwsd_pkg::ST_MUL:   state_nxt = hwsd_pkg::ST_SCALE;
      hwsd_pkg::ST_SCALE: begin
        if (travel_r == '0 || {{(DEN_W-NUM_W){1'b0}}, num_r} >= den_r)
          state_nxt = hwsd_pkg::ST_READ;
        else
          state_nxt = hwsd_pkg::ST_DIV_MAG;
      end
      hwsd_pkg::ST_DIV_MAG: if (cnt_r == 3'd0) state_nxt = hwsd_pkg::ST_READ;
      hwsd_pkg::ST_READ:    state_nxt = hwsd_pkg::ST_WRITE;
      hwsd_pkg::ST_WRITE:   state_nxt = stop_r ? hwsd_pkg::ST_DONE : hwsd_pkg::ST_DIV_AVG;
      hwsd_pkg::ST_DIV_AVG: state_nxt = hwsd_pkg::ST_DONE;
      hwsd_pkg::ST_DONE:    if (out_free) state_nxt = hwsd_pkg::ST_IDLE;
      default:              state_nxt = hwsd_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      elapsed_r   <= '0;
      halted_r    <= 1'b0;
      ptr_r       <= '0;
      total_r     <= '0;
      ring_vld_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (trig) begin
          prev_r    <= now;
          elapsed_r <= '0;
          halted_r  <= 1'b0;
        end else begin
          elapsed_r <= el_inc;
          if (stop_hit) halted_r <= 1'b1;
        end
      end
      if (state_r == hwsd_pkg::ST_READ) ptr_r <= ptr_inc;
      if (state_r == hwsd_pkg::ST_WRITE) begin
        total_r           <= total_nxt;
        ring_vld_r[ptr_r] <= 1'b1;
      end
      if (state_r == hwsd_pkg::ST_SCALE)
        cnt_r <= 3'(MAG_W - 1);
      else if (state_r == hwsd_pkg::ST_DIV_MAG && cnt_r != 3'd0)
        cnt_r <= cnt_r - 3'd1;
      if (state_r == hwsd_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                           out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r    <= el_inc;
      stop_r <= !trig;
      neg_r  <= dir_neg;
      mag_r  <= '0;
    end
    unique case (state_r)
      hwsd_pkg::ST_MUL: begin
        num_r <= NUM_W'({travel_r, 3'b000}) + NUM_W'({travel_r, 1'b0});
        den_r <= DEN_W'(top_r) * DEN_W'(t_r);
      end
      hwsd_pkg::ST_SCALE: begin
        if (travel_r == '0)                                  mag_r <= '0;
        else if ({{(DEN_W-NUM_W){1'b0}}, num_r} >= den_r)    mag_r <= full_r;
        rem_r <= PROD_W'(num_r) * PROD_W'(full_r);
        ds_r  <= {den_r, {hwsd_pkg::QSHIFT{1'b0}}};
        q_r   <= '0;
      end
      hwsd_pkg::ST_DIV_MAG: begin
        rem_r <= div_rem;
        ds_r  <= ds_r >> 1;
        q_r   <= div_q;
        if (cnt_r == 3'd0) mag_r <= div_q;
      end
      hwsd_pkg::ST_DIV_AVG: begin
        q_r <= avg_prod[RCP_SH +: MAG_W];
      end
      hwsd_pkg::ST_DONE: begin
        if (out_free) begin
          out_axis_r <= stop_r ? 8'sd0 : val_s[7:0];
          out_stop_r <= stop_r;
        end
      end
      default: ;
    endcase
  end

  // ring memory ports
  always_ff @(posedge clk) begin
    if (state_r == hwsd_pkg::ST_READ)  ring_rd_r       <= ring_mem[ptr_inc];
    if (state_r == hwsd_pkg::ST_WRITE) ring_mem[ptr_r] <= mag_r;
  end

  assign out_valid       = out_valid_r;
  assign out_axis_value  = out_axis_r;
  assign out_stop_report = out_stop_r;

  // the running total never exceeds a full ring at the top magnitude
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(TOT_MAX))
    else $error("ring total out of range");

  // a stop report always carries a zero axis value
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_report) |-> (out_axis_value == 8'sd0))
    else $error("stop report with nonzero value");

  // a stop report is only produced once the halted flag has been set
  a_stop_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hwsd_pkg::ST_DONE && stop_r) |-> halted_r)
    else $error("stop report without halt");

  // the divider pass starts from the full step count
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hwsd_pkg::ST_SCALE) |=> (cnt_r == 3'(MAG_W - 1)))
    else $error("divider pass started with wrong count");

endmodule

[tb/sv/tb_hall_wheel_speed_direction.sv]
// tb_hall_wheel_speed_direction: self-checking bench for the hall wheel speed/direction block
// predicts each tick in a local model of the ring average and direction logic
// depends on hwsd_pkg and hall_wheel_speed_direction
module tb_hall_wheel_speed_direction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAG_W        = hwsd_pkg::MAG_W;
  localparam int MS_W         = hwsd_pkg::MS_W;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_TICKS = 1780;
  localparam int IDLE_TICKS   = 40;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic signed [7:0] axis_value;
    logic              stop_report;
  } wheel_report_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_hall_inner;
  logic                            in_hall_middle;
  logic                            in_hall_outer;
  logic                            out_valid;
  logic                            out_ready = 1'b1;
  logic signed [7:0]               out_axis_value;
  logic                            out_stop_report;
  logic                            cfg_wr_en;
  logic [hwsd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hwsd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hall_wheel_speed_direction dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hall_inner   (in_hall_inner),
    .in_hall_middle  (in_hall_middle),
    .in_hall_outer   (in_hall_outer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_axis_value  (out_axis_value),
    .out_stop_report (out_stop_report),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // register shadows
  logic [15:0]      travel_set  = hwsd_pkg::TRAVEL_RST;
  logic [15:0]      top_set     = hwsd_pkg::TOP_RST;
  logic [MAG_W-1:0] full_set    = hwsd_pkg::FULL_RST;
  logic [15:0]      stop_set    = hwsd_pkg::STOP_RST;
  logic             invert_set  = 1'b0;
  logic             reverse_set = 1'b0;

  // wheel state as the block should hold it
  logic [2:0]       wheel_state = '0;
  logic [MS_W-1:0]  ms_count    = '0;
  logic             stopped     = 1'b0;
  int               ring_ptr    = 0;
  logic [MAG_W-1:0] ring_mag [hwsd_pkg::AVG_LEN_DEF] = '{default: '0};
  int               ring_sum    = 0;

  wheel_report_t    expected_reports [$];
  int               fail_count = 0;
  int               burst_left = 0;
  bit               idle_on    = 1'b1;

  int               ready_left = 0;
  int               ready_mode = 0;
  logic [15:0]      ready_bits = 16'hFFFF;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("tb_hall_wheel_speed_direction failed");
    $finish;
  end

  function automatic logic [MAG_W-1:0] speed_level(logic [MS_W-1:0] ticks);
    logic [63:0] num;
    logic [63:0] den;
    num = 64'(travel_set) * 64'd10;
    den = 64'(top_set) * 64'(ticks);
    if (travel_set == '0) return '0;
    if (num >= den) return full_set;
    return MAG_W'((num * 64'(full_set)) / den);
  endfunction

  function automatic logic [MAG_W-1:0] push_level(logic [MAG_W-1:0] lvl);
    ring_ptr = (ring_ptr + 1) % hwsd_pkg::AVG_LEN_DEF;
    ring_sum = ring_sum - int'(ring_mag[ring_ptr]) + int'(lvl);
    ring_mag[ring_ptr] = lvl;
    return MAG_W'(ring_sum / hwsd_pkg::AVG_LEN_DEF);
  endfunction

  function automatic void predict_wheel_tick(logic [2:0] hall);
    int            now;
    int            dir;
    int            level;
    wheel_report_t rep;
    now = int'(hall[0]) + 2 * int'(hall[1]) + 3 * int'(hall[2]);
    if (ms_count != hwsd_pkg::MS_MAX) ms_count++;
    if (now != 0 && now != int'(wheel_state)) begin
      level = int'(push_level(speed_level(ms_count)));
      case (wheel_state)
        3'd1: dir = (now == 2) ? 1 : -1;
        3'd2: dir = (now == 3) ? 1 : -1;
        3'd3: dir = (now == 1) ? 1 : -1;
        default: dir = 1;
      endcase
      if (reverse_set) dir = -dir;
      if (invert_set) level = int'(full_set) - level;
      wheel_state = 3'(now);
      ms_count = '0;
      stopped = 1'b0;
      rep.axis_value = 8'(dir * level);
      rep.stop_report = 1'b0;
      expected_reports.push_back(rep);
    end else if (!stopped && ms_count > stop_set) begin
      stopped = 1'b1;
      void'(push_level('0));
      rep.axis_value = '0;
      rep.stop_report = 1'b1;
      expected_reports.push_back(rep);
    end
  endfunction

  // hall bits are {outer, middle, inner}
  function automatic logic [2:0] hall_for(int st);
    case (st)
      1: return 3'b001;
      2: return 3'b010;
      default: return $urandom_range(0, 1) ? 3'b100 : 3'b011;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_tick(logic [2:0] hall);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    {in_hall_outer, in_hall_middle, in_hall_inner} <= hall;
    do @(posedge clk); while (!in_ready);
    predict_wheel_tick(hall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(hwsd_pkg::hwsd_reg_t idx, logic [hwsd_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic apply_settings(logic [15:0] travel, logic [15:0] top,
                                logic [MAG_W-1:0] full, logic [15:0] stop,
                                logic inv, logic rev);
    write_reg(hwsd_pkg::REG_TRAVEL, travel);
    write_reg(hwsd_pkg::REG_TOP, top);
    write_reg(hwsd_pkg::REG_FULL, {9'($urandom), full});
    write_reg(hwsd_pkg::REG_STOP, stop);
    write_reg(hwsd_pkg::REG_INVERT, {15'($urandom), inv});
    write_reg(hwsd_pkg::REG_REVERSE, {15'($urandom), rev});
    cfg_wr_en <= 1'b0;
    travel_set  = travel;
    top_set     = top;
    full_set    = full;
    stop_set    = stop;
    invert_set  = inv;
    reverse_set = rev;
  endtask

  task automatic test_directed_cases();
    settle();
    apply_settings(16'd100, 16'd100, 7'd127, 16'd3, 1'b0, 1'b0);
    send_tick(3'b001);
    send_tick(3'b010);
    send_tick(3'b011);             // inner plus middle also weighs 3
    send_tick(3'b001);
    send_tick(3'b100);             // backward step
    send_tick(3'b100);
    send_tick(3'b000);
    send_tick(3'b000);
    send_tick(3'b000);             // stop timeout fires here
    send_tick(3'b000);             // already halted
    send_tick(3'b101);             // multi-sensor states
    send_tick(3'b110);
    send_tick(3'b111);
    send_tick(3'b001);
    settle();
    // zero travel, reversed wheel, stop right after the trigger
    apply_settings(16'd0, 16'd1, 7'd127, 16'd0, 1'b0, 1'b1);
    send_tick(3'b010);
    send_tick(3'b000);
    settle();
    // top speed of zero always clamps
    apply_settings(16'hFFFF, 16'd0, 7'd1, 16'd65534, 1'b0, 1'b0);
    send_tick(3'b100);
    settle();
    apply_settings(16'hFFFF, 16'd1, 7'd127, 16'd65534, 1'b0, 1'b0);
    repeat (4) begin
      send_tick(3'b001);
      send_tick(3'b010);
    end
    settle();
    // average now above full scale, inverted result goes negative
    apply_settings(16'hFFFF, 16'd1, 7'd0, 16'd65534, 1'b1, 1'b0);
    send_tick(3'b100);
  endtask

  task automatic test_random_rotation();
    int          sent;
    int          phase;
    int          phase_end;
    int          rot_state;
    int          spin;
    int          hold;
    int          r;
    int unsigned span;
    logic [15:0] travel;
    logic [15:0] top;
    logic [6:0]  full;
    logic [15:0] stop;
    logic [2:0]  filler;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_TICKS) begin
      settle();
      r = $urandom_range(0, 19);
      travel = (r == 0) ? 16'd0 : (r < 3) ? 16'hFFFF : 16'($urandom_range(20, 3000));
      r = $urandom_range(0, 9);
      if (r == 0) top = 16'd1;
      else if (r == 1) top = 16'hFFFF;
      else begin
        span = int'(travel) * 10 / $urandom_range(1, 8);
        top = (span == 0) ? 16'd1 : (span > 65535) ? 16'hFFFF : 16'(span);
      end
      r = $urandom_range(0, 9);
      full = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(1, 127));
      r = $urandom_range(0, 9);
      if (r == 0) stop = 16'd0;
      else if (r == 1) stop = 16'd65534;
      else if (r == 2) stop = 16'($urandom_range(41, 65534));
      else stop = 16'($urandom_range(1, 40));
      apply_settings(travel, top, full, stop, 1'($urandom), 1'($urandom));
      idle_on = (phase % 4 != 3);
      rot_state = int'(wheel_state);
      if (rot_state < 1 || rot_state > 3) rot_state = 1;
      spin = $urandom_range(0, 1) ? 1 : -1;
      phase_end = sent + $urandom_range(100, 200);
      while (sent < phase_end && sent < RANDOM_TICKS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          if (r < 8 && stop_set <= 60) hold = int'(stop_set) + $urandom_range(1, 3);
          else hold = $urandom_range(0, 12);
          filler = $urandom_range(0, 1) ? hall_for(rot_state) : 3'b000;
          repeat (hold) begin
            send_tick(filler);
            sent++;
          end
          if ($urandom_range(0, 9) == 0) spin = -spin;
          rot_state = (spin > 0) ? rot_state % 3 + 1 : (rot_state + 1) % 3 + 1;
          send_tick(hall_for(rot_state));
          sent++;
        end else begin
          send_tick(3'($urandom));
          sent++;
        end
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  task automatic test_long_idle();
    settle();
    apply_settings(16'd100, 16'd100, 7'd127, 16'd20, 1'b0, 1'b0);
    idle_on = 1'b0;
    send_tick(3'b010);
    send_tick(3'b001);
    // one stop report after the delay, then nothing
    repeat (IDLE_TICKS) send_tick(3'b000);
    settle();
    apply_settings(16'hFFFF, 16'hFFFF, 7'd127, 16'd65534, 1'b1, 1'b1);
    send_tick(3'b100);
    send_tick(3'b001);
    send_tick(3'b010);
    idle_on = 1'b1;
  endtask

  // receiver stalls: always ready, rotating bit pattern, two such bits ORed, or random draws
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(8, 64);
      ready_bits = 16'($urandom);
    end
    ready_left--;
    ready_bits = {ready_bits[14:0], ready_bits[15]};
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ready_bits[0];
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ready_bits[0] | ready_bits[1];
    endcase
  end

  always @(posedge clk) begin : check_reports
    wheel_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_PRINTS)
          $display("%0t: unexpected report axis_value %0d stop_report %0b",
                   $time, out_axis_value, out_stop_report);
      end else begin
        want = expected_reports.pop_front();
        if (out_axis_value !== want.axis_value) begin
          fail_count++;
          if (fail_count <= MAX_PRINTS)
            $display("%0t: axis_value expected %0d got %0d",
                     $time, want.axis_value, out_axis_value);
        end
        if (out_stop_report !== want.stop_report) begin
          fail_count++;
          if (fail_count <= MAX_PRINTS)
            $display("%0t: stop_report expected %0b got %0b",
                     $time, want.stop_report, out_stop_report);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_hall_inner  = 1'b0;
    in_hall_middle = 1'b0;
    in_hall_outer  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = hwsd_pkg::REG_TRAVEL;
    cfg_wdata      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_random_rotation();
    test_long_idle();
    settle();
    if (fail_count == 0) begin
      $display("tb_hall_wheel_speed_direction passed");
    end else begin
      $display("tb_hall_wheel_speed_direction failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/hwsd_pkg.sv
hw/rtl/hall_wheel_speed_direction.sv
tb/sv/tb_hall_wheel_speed_direction.sv
